// ----- rtl/bfiq_pkg.sv -----
package bfiq_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic [31:0] C1      = 32'hcc9e2d51;
    localparam logic [31:0] C2      = 32'h1b873593;
    localparam logic [31:0] C_ADD   = 32'he6546b64;
    localparam logic [31:0] F1      = 32'h85ebca6b;
    localparam logic [31:0] F2      = 32'hc2b2ae35;
    localparam logic [31:0] SEED    = 32'd42;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] word;
        logic [2:0]  vb;
        logic        last;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_FOLD,
        ST_FIN1,
        ST_FIN2,
        ST_DIV,
        ST_RD,
        ST_ACT,
        ST_CLR
    } t_state;

endpackage

// ----- rtl/bloom_filter_insert_query_core.sv -----
// Bloom filter with one MurmurHash3 x86_32 hash (seed 42). Keys arrive one 32-bit word per
// transaction (start while busy is low); a word is taken into a two-entry queue and the hash
// unit folds it in through states MUL1, MUL2 and FOLD. The last word adds the finalizer
// and a 32-step bit-serial modulo by filter_bytes; an insert or query result then shows on
// o_valid for one cycle, and results cannot be held off. A clear zeroes the store one byte
// per cycle; the same sweep runs after reset before the first key word.
module bloom_filter_insert_query_core #(
    parameter int STORE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_key_bytes,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last,
    output logic        o_valid,
    output logic [1:0]  o_result_kind,
    output logic        o_member,
    output logic [11:0] o_block_index,
    output logic [2:0]  o_bit_index
);
    import bfiq_pkg::*;

    logic [12:0] r_filter_bytes;
    t_item in_item, q_item;
    logic full, empty, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bytes <= 13'd4096;
        end else if (i_cfg_we) begin
            r_filter_bytes <= i_cfg_wdata;
        end
    end

    assign busy = full;
    assign in_item.kind = t_kind'(i_kind);
    assign in_item.word = i_key_bytes;
    assign in_item.vb   = i_valid_bytes;
    assign in_item.last = i_last;

    bfiq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !full),
        .i_item  (in_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (q_item)
    );

    bfiq_back #(.STORE_BYTES(STORE_BYTES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_filter_bytes (r_filter_bytes),
        .i_empty        (empty),
        .i_item         (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_member       (o_member),
        .o_block_index  (o_block_index),
        .o_bit_index    (o_bit_index)
    );
endmodule

// ----- rtl/bfiq_ram.sv -----
module bfiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/bfiq_front.sv -----
module bfiq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bfiq_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bfiq_pkg::t_item o_item
);
    import bfiq_pkg::*;

    t_item r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end
endmodule

// ----- rtl/bfiq_back.sv -----
module bfiq_back #(
    parameter int STORE_BYTES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [12:0]     i_filter_bytes,
    input  logic            i_empty,
    input  bfiq_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    output logic [1:0]      o_result_kind,
    output logic            o_member,
    output logic [11:0]     o_block_index,
    output logic [2:0]      o_bit_index
);
    import bfiq_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int MW = $clog2(STORE_BYTES + 1);

    t_state r_state, n_state;
    t_item  r_it;
    logic [31:0] r_h, r_len, r_k, r_f;
    logic [31:0] r_q;
    logic [MW:0] r_rem;
    logic [MW-1:0] r_m;
    logic [5:0]  r_cnt;
    logic [AW-1:0] r_clr;
    logic        r_clr_busy;
    logic [AW-1:0] r_blk;
    logic [2:0]  r_bit;
    logic [1:0]  r_okind;
    logic        r_ovalid, r_omem;
    logic [11:0] r_oblk;
    logic [2:0]  r_obit;

    logic [2:0]  vb;
    logic        fin;
    logic [31:0] mask, h1, hx, hm;
    logic [MW:0] rem_sh;
    logic [7:0]  rdata;
    logic        we;
    logic [AW-1:0] waddr;
    logic [7:0]  wdata;
    logic [MW-1:0] m_sel;

    always_comb begin
        vb = (i_item.vb > 3'd4) ? 3'd4 : i_item.vb;
        unique case (r_it.vb)
            3'd0:    mask = 32'h0;
            3'd1:    mask = 32'hff;
            3'd2:    mask = 32'hffff;
            3'd3:    mask = 32'hffffff;
            default: mask = 32'hffffffff;
        endcase
        fin = (r_it.vb != 3'd4) || r_it.last;
        h1 = r_h ^ {r_k[31:0]};
        hx = r_h ^ r_len;
        hm = r_f;
        rem_sh = {r_rem[MW-1:0], r_q[31]};
        if (i_filter_bytes == 13'd0) begin
            m_sel = MW'(1);
        end else if (32'(i_filter_bytes) > 32'(STORE_BYTES)) begin
            m_sel = MW'(STORE_BYTES);
        end else begin
            m_sel = MW'(i_filter_bytes);
        end
    end

    bfiq_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_blk),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        we      = 1'b0;
        waddr   = r_blk;
        wdata   = rdata | (8'd1 << r_bit);
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_item.kind == KIND_CLEAR) begin
                        n_state = ST_CLR;
                    end else if (i_item.kind != KIND_NONE) begin
                        n_state = ST_MUL1;
                    end
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_FOLD;
            ST_FOLD: n_state = fin ? ST_FIN1 : ST_IDLE;
            ST_FIN1: n_state = ST_FIN2;
            ST_FIN2: n_state = ST_DIV;
            ST_DIV:  n_state = (r_cnt == 6'd35) ? ST_RD : ST_DIV;
            ST_RD:   n_state = ST_ACT;
            ST_ACT: begin
                we = (r_it.kind == KIND_INSERT);
                n_state = ST_IDLE;
            end
            ST_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = 8'd0;
                if (r_clr == AW'(STORE_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_clr_busy) begin
            o_pop = 1'b0;
            n_state = ST_IDLE;
            we    = 1'b1;
            waddr = r_clr;
            wdata = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_h        <= SEED;
            r_len      <= 32'd0;
            r_clr      <= '0;
            r_clr_busy <= 1'b1;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_state == ST_ACT)
                || (r_state == ST_CLR && r_clr == AW'(STORE_BYTES - 1));
            if (r_clr_busy) begin
                r_clr <= (r_clr == AW'(STORE_BYTES - 1)) ? '0 : r_clr + AW'(1);
                if (r_clr == AW'(STORE_BYTES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_it  <= '{kind: i_item.kind, word: i_item.word, vb: vb,
                                   last: i_item.last};
                        r_clr <= '0;
                    end
                end
                ST_MUL1: begin
                    r_k <= ((r_it.vb == 3'd4 && !r_it.last) || r_it.vb != 3'd4)
                        ? (r_it.word & mask) * C1 : r_it.word * C1;
                end
                ST_MUL2: r_k <= {r_k[16:0], r_k[31:17]} * C2;
                ST_FOLD: begin
                    if (r_it.vb == 3'd4) begin
                        r_h   <= ({h1[18:0], h1[31:19]} * 32'd5) + C_ADD;
                        r_len <= r_len + 32'd4;
                        if (r_it.last) begin
                            r_it.vb <= 3'd0;
                            r_it.last <= 1'b1;
                        end
                    end else begin
                        r_h   <= h1;
                        r_len <= r_len + 32'(r_it.vb);
                    end
                end
                ST_FIN1: begin
                    r_f <= (hx ^ (hx >> 16)) * F1;
                end
                ST_FIN2: begin
                    r_f <= ((hm ^ (hm >> 13)) * F2);
                    r_cnt <= 6'd0;
                end
                ST_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_q   <= r_f ^ (r_f >> 16);
                        r_rem <= '0;
                        r_m   <= m_sel;
                    end else if (r_cnt <= 6'd32) begin
                        if (rem_sh >= {1'b0, r_m}) begin
                            r_rem <= rem_sh - {1'b0, r_m};
                            r_q   <= {r_q[30:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_q   <= {r_q[30:0], 1'b0};
                        end
                    end else begin
                        r_blk <= AW'(r_rem);
                        r_bit <= r_q[2:0];
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                ST_RD: ;
                ST_ACT: begin
                    r_okind  <= r_it.kind;
                    r_omem   <= (r_it.kind == KIND_QUERY) ? rdata[r_bit] : 1'b0;
                    r_oblk   <= 12'(r_blk);
                    r_obit   <= r_bit;
                    r_h      <= SEED;
                    r_len    <= 32'd0;
                end
                ST_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(STORE_BYTES - 1)) begin
                        r_okind  <= KIND_CLEAR;
                        r_omem   <= 1'b0;
                        r_oblk   <= 12'd0;
                        r_obit   <= 3'd0;
                        r_h      <= SEED;
                        r_len    <= 32'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_member      = r_omem;
    assign o_block_index = r_oblk;
    assign o_bit_index   = r_obit;
endmodule

// ----- rtl/bfiq_checker.sv -----
module bfiq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic [1:0]  o_result_kind,
    input logic        o_member,
    input logic [11:0] o_block_index,
    input logic [2:0]  o_bit_index
);
    import bfiq_pkg::*;

    a_no_kind3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result_kind != KIND_NONE) else $error("bad result kind");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_CLEAR) |-> (o_block_index == 12'd0
        && o_bit_index == 3'd0 && !o_member)) else $error("clear result not zero");
    a_insert_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_INSERT) |-> !o_member)
        else $error("insert member set");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("back to back results");
endmodule

bind bloom_filter_insert_query_core bfiq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .o_result_kind(o_result_kind), .o_member(o_member),
    .o_block_index(o_block_index), .o_bit_index(o_bit_index)
);
